### sv/sorted_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} spq_status_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] order_tag;
		logic [2:0]  prio;
	} spq_in_t;

	typedef struct packed {
		spq_status_t status;
		logic [15:0] out_tag;
		logic [2:0]  out_prio;
		logic [6:0]  occupancy;
	} spq_out_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [2:0]  prio;
	} spq_entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_REM_OUT
	} spq_state_t;

	// controller -> datapath
	typedef struct packed {
		logic        load;     // latch command, set up insert walk
		logic        rd_head;  // read address is head, else slot before walk pointer
		logic        shift;    // move read entry one slot back
		logic        place;    // write new entry at walk pointer, count up
		logic        pop;      // drop head, count down
		logic        emit;     // present a result beat
		spq_status_t status;
	} spq_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic lower;   // entry read is of strictly lower priority than new one
	} spq_sts_t;

endpackage

`default_nettype wire

### sv/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// Command sequencer for the sorted priority queue: insert walk and remove.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire spq_pkg::spq_in_t item,
	input  wire spq_pkg::spq_sts_t sts,
	output spq_pkg::spq_ctl_t     ctl,
	output logic                  busy
);
	import spq_pkg::*;

	spq_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ctl         = '0;
		ctl.status  = ST_INSERTED;
		unique case (state_q)
			S_IDLE: begin
				ctl.rd_head = 1'b1;
				if (start) begin
					if (item.cmd == CMD_INSERT) begin
						if (sts.full) begin
							ctl.emit   = 1'b1;
							ctl.status = ST_FULL;
						end else begin
							ctl.load  = 1'b1;
							state_nxt = S_INS_CHK;
						end
					end else begin
						if (sts.empty) begin
							ctl.emit   = 1'b1;
							ctl.status = ST_EMPTY;
						end else begin
							state_nxt = S_REM_OUT;
						end
					end
				end
			end
			S_INS_CHK: begin
				if (sts.pos_zero) begin
					ctl.place  = 1'b1;
					ctl.emit   = 1'b1;
					ctl.status = ST_INSERTED;
					state_nxt  = S_IDLE;
				end else begin
					state_nxt = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.lower) begin
					ctl.shift = 1'b1;
					state_nxt = S_INS_CHK;
				end else begin
					ctl.place  = 1'b1;
					ctl.emit   = 1'b1;
					ctl.status = ST_INSERTED;
					state_nxt  = S_IDLE;
				end
			end
			S_REM_OUT: begin
				ctl.pop    = 1'b1;
				ctl.emit   = 1'b1;
				ctl.status = ST_REMOVED;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

### sv/spq_datapath.sv
// ---------------------------------------------------------------------------
// spq_datapath
// Circular entry store with head pointer, fill count, insert walk pointer
// and registered result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module spq_datapath #(
	parameter int DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spq_pkg::spq_in_t  item,
	input  wire spq_pkg::spq_ctl_t ctl,
	output spq_pkg::spq_sts_t      sts,
	output logic                   done,
	output spq_pkg::spq_out_t      result
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	spq_entry_t mem [DEPTH];
	spq_entry_t rd_q;

	spq_in_t       item_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] p_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] fill_q;
	logic          done_q;
	spq_out_t      res_q;

	logic [AW:0]   tail_sum;
	logic [AW:0]   tail_wrap;
	logic [AW-1:0] tail;
	logic [AW-1:0] p_prev;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] rd_addr;
	logic          we;
	spq_entry_t    wd;
	logic [CW-1:0] fill_nxt;
	logic [CW+6:0] occ_ext;

	// physical slot just past the last entry: head + fill, wrapped once
	assign tail_sum  = (AW+1)'(head_q) + (AW+1)'(fill_q);
	assign tail_wrap = tail_sum - (AW+1)'(DEPTH);
	assign tail      = (tail_sum >= (AW+1)'(DEPTH)) ? tail_wrap[AW-1:0] : tail_sum[AW-1:0];

	assign p_prev   = (p_q == '0) ? AW'(DEPTH - 1) : p_q - 1'b1;
	assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign rd_addr  = ctl.rd_head ? head_q : p_prev;

	assign we = ctl.shift | ctl.place;
	always_comb begin
		if (ctl.shift) begin
			wd = rd_q;
		end else begin
			wd.tag  = item_q.order_tag;
			wd.prio = item_q.prio;
		end
	end

	always_comb begin
		priority if (ctl.place) begin
			fill_nxt = fill_q + 1'b1;
		end else if (ctl.pop) begin
			fill_nxt = fill_q - 1'b1;
		end else begin
			fill_nxt = fill_q;
		end
	end

	assign occ_ext = {7'b0, fill_nxt};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[p_q] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			head_q <= '0;
			done_q <= 1'b0;
		end else begin
			fill_q <= fill_nxt;
			done_q <= ctl.emit;
			if (ctl.pop) begin
				head_q <= head_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
			p_q    <= tail;
			pos_q  <= fill_q;
		end else if (ctl.shift) begin
			p_q   <= p_prev;
			pos_q <= pos_q - 1'b1;
		end
		if (ctl.emit) begin
			res_q.status    <= ctl.status;
			res_q.out_tag   <= ctl.pop ? rd_q.tag : 16'd0;
			res_q.out_prio  <= ctl.pop ? rd_q.prio : 3'd0;
			res_q.occupancy <= occ_ext[6:0];
		end
	end

	assign sts.full     = (fill_q == CW'(DEPTH));
	assign sts.empty    = (fill_q == '0);
	assign sts.pos_zero = (pos_q == '0);
	assign sts.lower    = (rd_q.prio < item_q.prio);

	assign done   = done_q;
	assign result = res_q;

	`SPQ_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(DEPTH), "fill count above depth")
	`SPQ_ASSERT_IMP(a_place_room, clk, arst_n, ctl.place, fill_q < CW'(DEPTH), "insert into full store")
	`SPQ_ASSERT_IMP(a_pop_data, clk, arst_n, ctl.pop, fill_q != '0, "remove from empty store")
	`SPQ_ASSERT_NXT(a_place_count, clk, arst_n, ctl.place, fill_q == $past(fill_q) + 1'b1, "count missed insert")
	`SPQ_ASSERT_IMP(a_shift_walk, clk, arst_n, ctl.shift, pos_q != '0, "walk ran past the head")

endmodule

`default_nettype wire

### sv/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue, sorted by descending priority, FIFO among equals.
//
//   channel   handshake             payload
//   command   start, busy (out)     item   : cmd, order_tag, prio
//   result    done (one-cycle beat) result : status, out_tag, out_prio, occupancy
//
// A command beat is taken at a rising edge with start high and busy low.
// Its result beat shows on done/result in the cycle after the command ends;
// busy is already low then, so the next command may be taken in that cycle.
// Refused insert (full) or remove from empty is answered from idle. Remove reads
// the head, then pops it. Insert walks back from the tail, moving each entry of
// lower priority one slot back with a read and a write on the entry store, and
// places the new entry where it stops (at the head if the queue was empty).
// No clearing pass after reset; the receiver cannot stall results.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
	parameter int DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire spq_pkg::spq_in_t item,
	output logic                  busy,
	output logic                  done,
	output spq_pkg::spq_out_t     result
);
	import spq_pkg::*;

	spq_ctl_t ctl;
	spq_sts_t sts;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	spq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
